// File: hdl/frtm_pkg.sv
// ----------------------------------------------------------------------------
// frtm_pkg
// Shared constants and types of the frame rate and throughput meter.
// ----------------------------------------------------------------------------
`default_nettype none
package frtm_pkg;
  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam int unsigned MIN_KEPT_DEF    = 2;

  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd50;
  localparam logic [39:0] MAX_SPAN_RST    = 40'd5000000000;

  // Rate scale factors
  localparam logic [39:0] FPS_SCALE  = 40'd100000000000;
  localparam logic [39:0] MBPS_SCALE = 40'd800000;
  localparam logic [31:0] RATE_MAX   = 32'hFFFF_FFFF;

  // Register indexes
  localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [0:0] REG_MAX_SPAN    = 1'b1;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Divider request and answer
  typedef struct packed {
    logic        start;
    logic [87:0] dividend;
    logic [62:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: hdl/frtm_div.sv
// ----------------------------------------------------------------------------
// frtm_div
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module frtm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frtm_pkg::div_req_t req,
  output frtm_pkg::div_rsp_t     rsp
);
  import frtm_pkg::*;

  localparam int unsigned NB = 88;

  logic [NB-1:0] num;
  logic [NB-1:0] quot;
  logic [63:0]   rem;
  logic [62:0]   den;
  logic [6:0]    cnt;
  logic          busy;
  logic          done;
  logic [31:0]   sat_quot;
  logic [63:0]   trial;
  logic [63:0]   shifted;

  always_comb begin
    shifted = {rem[62:0], num[NB-1]};
    trial   = shifted - {1'b0, den};
  end

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        quot <= '0;
        cnt  <= 7'(NB - 1);
      end else if (busy) begin
        num <= {num[NB-2:0], 1'b0};
        if (!trial[63]) begin
          rem  <= trial;
          quot <= {quot[NB-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[NB-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

  assign sat_quot = (quot[NB-1:32] != '0) ? RATE_MAX : quot[31:0];
  assign rsp      = {done, sat_quot};
endmodule
`default_nettype wire

// File: hdl/frame_rate_throughput_meter_core.sv
// ----------------------------------------------------------------------------
// frame_rate_throughput_meter_core
// Sliding window frame rate and throughput meter.
// ----------------------------------------------------------------------------
// Each transaction (a frame event or a clear) yields one result. A frame is
// written into a circular window held in a memory with one read port; the
// sequencer drops old entries one at a time (read, then update), then, if
// the window gives valid rates, runs two 88-step restoring divisions on one
// shared divider. The block is not ready while an item is at work or while
// a result waits, so the next transaction is taken in the cycle after the
// result is.
`default_nettype none
module frame_rate_throughput_meter_core #(
  parameter int unsigned STORE_DEPTH = frtm_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MIN_KEPT    = frtm_pkg::MIN_KEPT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:3]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [31:0] frame_size,
  input  wire logic [62:0] timestamp_ns,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [62:0]      total_frames,
  output logic [6:0]       window_frames,
  output logic [62:0]      window_span_ns,
  output logic [47:0]      window_bytes,
  output logic [31:0]      fps_x100,
  output logic [31:0]      mbps_x100,
  output logic             rates_valid
);
  import frtm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAPRD  = 4'd1;
  localparam logic [3:0] S_CAPDRP = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_PRRD   = 4'd4;
  localparam logic [3:0] S_PRCHK  = 4'd5;
  localparam logic [3:0] S_FPS    = 4'd6;
  localparam logic [3:0] S_FPSW   = 4'd7;
  localparam logic [3:0] S_MBPS   = 4'd8;
  localparam logic [3:0] S_MBPSW  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]    state;
  logic [6:0]    max_entries;
  logic [39:0]   max_span_ns;
  logic [62:0]   stamp_mem [STORE_DEPTH];
  logic [31:0]   size_mem  [STORE_DEPTH];
  logic [62:0]   rd_stamp;
  logic [31:0]   rd_size;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] count;
  logic [47:0]   byte_total;
  logic [62:0]   frame_total;
  logic [62:0]   last_stamp;
  logic [31:0]   cur_size;
  logic [62:0]   span;
  logic [CW-1:0] cap;
  logic          wr_en;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          prune_drop;
  logic          win_ok;
  logic          clear_acc;
  logic          result_set;
  div_req_t      dreq;
  div_rsp_t      drsp;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
      max_span_ns <= MAX_SPAN_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_MAX_ENTRIES) max_entries <= pwdata[6:0];
      else                             max_span_ns <= pwdata[39:0];
    end
  end
  assign prdata = (paddr[3] == REG_MAX_ENTRIES) ? {57'd0, max_entries}
                                                : {24'd0, max_span_ns};

  // Clamp capacity to store depth, and zero to one
  always_comb begin
    if ({25'd0, max_entries} > STORE_DEPTH) cap = CW'(STORE_DEPTH);
    else if (max_entries == '0)             cap = CW'(1);
    else                                    cap = CW'(max_entries);
  end

  // Wrap window pointers at the store depth
  assign head_inc = (head == AW'(STORE_DEPTH - 1)) ? '0 : AW'(head + AW'(1));
  assign tail_sum = {1'b0, head} + (AW+1)'(count);
  assign tail     = (tail_sum >= (AW+1)'(STORE_DEPTH))
                    ? AW'(tail_sum - (AW+1)'(STORE_DEPTH)) : AW'(tail_sum);

  assign wr_en    = (state == S_STORE);
  assign in_ready = (state == S_IDLE) && !out_valid;

  // Window memory, registered read of the oldest entry
  assign rd_addr = head;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[tail] <= last_stamp;
      size_mem[tail]  <= cur_size;
    end
    rd_stamp <= stamp_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
  end

  // Span from oldest stamp as read
  always_comb begin
    if (count < CW'(2) || last_stamp < rd_stamp) span = '0;
    else                                          span = last_stamp - rd_stamp;
  end

  assign prune_drop = (count > CW'(MIN_KEPT)) && (span > {23'd0, max_span_ns});
  assign win_ok     = (count > CW'(1)) && (span != '0);
  assign clear_acc  = (state == S_IDLE) && in_valid && in_ready && (req_type == REQ_CLEAR);
  assign result_set = clear_acc || (state == S_OUT) ||
                      ((state == S_PRCHK) && !prune_drop && !win_ok);

  frtm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      count       <= '0;
      byte_total  <= '0;
      frame_total <= '0;
      out_valid   <= 1'b0;
      dreq.start  <= 1'b0;
    end else begin
      dreq.start <= (state == S_FPS) || (state == S_MBPS);
      if (result_set)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (req_type == REQ_CLEAR) begin
              head           <= '0;
              count          <= '0;
              byte_total     <= '0;
              frame_total    <= '0;
              total_frames   <= '0;
              window_frames  <= '0;
              window_span_ns <= '0;
              window_bytes   <= '0;
              fps_x100       <= '0;
              mbps_x100      <= '0;
              rates_valid    <= 1'b0;
            end else begin
              last_stamp <= timestamp_ns;
              cur_size   <= frame_size;
              state      <= S_CAPRD;
            end
          end
        end
        S_CAPRD: begin
          // Memory read of head lands next cycle
          if (count >= cap) state <= S_CAPDRP;
          else              state <= S_STORE;
        end
        S_CAPDRP: begin
          byte_total <= byte_total - {16'd0, rd_size};
          head       <= head_inc;
          count      <= count - CW'(1);
          state      <= S_CAPRD;
        end
        S_STORE: begin
          count       <= count + CW'(1);
          byte_total  <= byte_total + {16'd0, cur_size};
          frame_total <= frame_total + 63'd1;
          state       <= S_PRRD;
        end
        S_PRRD: state <= S_PRCHK;
        S_PRCHK: begin
          if (prune_drop) begin
            byte_total <= byte_total - {16'd0, rd_size};
            head       <= head_inc;
            count      <= count - CW'(1);
            state      <= S_PRRD;
          end else begin
            total_frames   <= frame_total;
            window_frames  <= 7'(count);
            window_span_ns <= span;
            window_bytes   <= byte_total - {16'd0, rd_size};
            rates_valid    <= win_ok;
            fps_x100       <= '0;
            mbps_x100      <= '0;
            if (win_ok) state <= S_FPS;
            else        state <= S_IDLE;
          end
        end
        S_FPS: begin
          dreq.dividend <= 88'(7'(count) - 7'd1) * 88'(FPS_SCALE);
          dreq.divisor  <= window_span_ns;
          state         <= S_FPSW;
        end
        S_FPSW: begin
          if (drsp.done) begin
            fps_x100 <= drsp.quot;
            state    <= S_MBPS;
          end
        end
        S_MBPS: begin
          dreq.dividend <= 88'(window_bytes) * 88'(MBPS_SCALE);
          state         <= S_MBPSW;
        end
        S_MBPSW: begin
          if (drsp.done) begin
            mbps_x100 <= drsp.quot;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/frtm_checker.sv
// ----------------------------------------------------------------------------
// frtm_checker
// Port-level checks of the meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module frtm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  window_frames,
  input wire logic [62:0] window_span_ns,
  input wire logic [31:0] fps_x100,
  input wire logic        rates_valid
);
  // Hold result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_frames))
    else $error("result changed while stalled");

  // No new transaction while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

  // Invalid rates read zero
  a_rates_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rates_valid |-> fps_x100 == 32'd0)
    else $error("rate nonzero while invalid");

  // Valid rates need two frames and a span
  a_valid_cond: assert property (@(posedge clk) disable iff (rst)
    out_valid && rates_valid |-> window_frames > 7'd1 && window_span_ns != 63'd0)
    else $error("rates valid without window");
endmodule

bind frame_rate_throughput_meter_core frtm_checker u_frtm_checker (.*);
`default_nettype wire
